// File: design/bcr_pkg.sv
// ----------------------------------------------------------------------------
// bcr_pkg: shared types and constants
// Register indexes, failsafe and led codes, configuration and item structs
// for the battery charge relay controller.
// ----------------------------------------------------------------------------
package bcr_pkg;

	localparam int PCT_W       = 8;
	localparam int CFG_TICK_W  = 16;
	localparam int FS_MODE_W   = 2;
	localparam int LED_W       = 2;
	localparam int REG_INDEX_W = 3;
	localparam int REG_DATA_W  = 16;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_START_PERCENT      = 3'd0,
		REG_STOP_PERCENT       = 3'd1,
		REG_MAX_VALID_PERCENT  = 3'd2,
		REG_STALE_TICKS        = 3'd3,
		REG_FAILSAFE_MODE      = 3'd4,
		REG_FAILSAFE_ON_TICKS  = 3'd5,
		REG_FAILSAFE_OFF_TICKS = 3'd6,
		REG_LED_SEEN_TICKS     = 3'd7
	} reg_index_t;

	localparam logic [FS_MODE_W-1:0] FS_MODE_OFF   = 2'd0;
	localparam logic [FS_MODE_W-1:0] FS_MODE_ON    = 2'd1;
	localparam logic [FS_MODE_W-1:0] FS_MODE_CYCLE = 2'd2;

	localparam logic [LED_W-1:0] LED_OFF      = 2'd0;
	localparam logic [LED_W-1:0] LED_LINK     = 2'd1;
	localparam logic [LED_W-1:0] LED_NO_LINK  = 2'd2;

	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_PACKET = 1'b1;

	typedef struct packed {
		logic [PCT_W-1:0]      start_percent;
		logic [PCT_W-1:0]      stop_percent;
		logic [PCT_W-1:0]      max_valid_percent;
		logic [CFG_TICK_W-1:0] stale_ticks;
		logic [FS_MODE_W-1:0]  failsafe_mode;
		logic [CFG_TICK_W-1:0] failsafe_on_ticks;
		logic [CFG_TICK_W-1:0] failsafe_off_ticks;
		logic [CFG_TICK_W-1:0] led_seen_ticks;
	} cfg_t;

	typedef struct packed {
		logic             kind;
		logic             ignition;
		logic [PCT_W-1:0] batt_level;
		logic             charge_flag;
	} item_t;

	typedef struct packed {
		logic             relay_on;
		logic             charging_state;
		logic [LED_W-1:0] led_status;
		logic             failsafe_on;
		logic             flag_mismatch;
		logic             scan_enable;
	} result_t;

endpackage

// File: design/bcr_cfg.sv
// ----------------------------------------------------------------------------
// bcr_cfg: configuration register file
// Holds the eight control registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bcr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             write_enable,
	input  logic [bcr_pkg::REG_INDEX_W-1:0]  reg_index,
	input  logic [bcr_pkg::REG_DATA_W-1:0]   write_data,
	output bcr_pkg::cfg_t                    cfg
);
	import bcr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_percent      <= 8'd20;
			cfg_q.stop_percent       <= 8'd80;
			cfg_q.max_valid_percent  <= 8'd100;
			cfg_q.stale_ticks        <= 16'd600;
			cfg_q.failsafe_mode      <= FS_MODE_CYCLE;
			cfg_q.failsafe_on_ticks  <= 16'd3000;
			cfg_q.failsafe_off_ticks <= 16'd3000;
			cfg_q.led_seen_ticks     <= 16'd50;
		end else if (write_enable) begin
			case (reg_index_t'(reg_index))
				REG_START_PERCENT:      cfg_q.start_percent      <= write_data[PCT_W-1:0];
				REG_STOP_PERCENT:       cfg_q.stop_percent       <= write_data[PCT_W-1:0];
				REG_MAX_VALID_PERCENT:  cfg_q.max_valid_percent  <= write_data[PCT_W-1:0];
				REG_STALE_TICKS:        cfg_q.stale_ticks        <= write_data[CFG_TICK_W-1:0];
				REG_FAILSAFE_MODE:      cfg_q.failsafe_mode      <= write_data[FS_MODE_W-1:0];
				REG_FAILSAFE_ON_TICKS:  cfg_q.failsafe_on_ticks  <= write_data[CFG_TICK_W-1:0];
				REG_FAILSAFE_OFF_TICKS: cfg_q.failsafe_off_ticks <= write_data[CFG_TICK_W-1:0];
				REG_LED_SEEN_TICKS:     cfg_q.led_seen_ticks     <= write_data[CFG_TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/bcr_core.sv
// ----------------------------------------------------------------------------
// bcr_core: controller state and update logic
// Applies one tick or packet item to the controller state and gives the
// state after the item; the state registers load when the item advances.
// ----------------------------------------------------------------------------
module bcr_core #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  bcr_pkg::item_t   item,
	input  bcr_pkg::cfg_t    cfg,
	output bcr_pkg::result_t result
);
	import bcr_pkg::*;

	localparam int TW    = TICK_COUNT_BITS;
	localparam int CMP_W = (TICK_COUNT_BITS > CFG_TICK_W) ? TICK_COUNT_BITS : CFG_TICK_W;
	localparam logic [TW-1:0] TICK_MAX = '1;

	logic             ign_q, init_pend_q, charge_q, relay_q, have_pkt_q;
	logic             fs_active_q, fs_out_q, mismatch_q;
	logic [LED_W-1:0] led_q;
	logic [TW-1:0]    tsp_q, tsi_q, fph_q;

	logic             ign_d, init_pend_d, charge_d, relay_d, have_pkt_d;
	logic             fs_active_d, fs_out_d, mismatch_d;
	logic [LED_W-1:0] led_d;
	logic [TW-1:0]    tsp_d, tsi_d, fph_d;

	always_comb begin
		logic          want, drive, entered, fs_go;
		logic [TW-1:0] age;
		logic [CFG_TICK_W-1:0] limit;

		ign_d       = ign_q;
		init_pend_d = init_pend_q;
		charge_d    = charge_q;
		relay_d     = relay_q;
		have_pkt_d  = have_pkt_q;
		fs_active_d = fs_active_q;
		fs_out_d    = fs_out_q;
		mismatch_d  = mismatch_q;
		led_d       = led_q;
		tsp_d       = tsp_q;
		tsi_d       = tsi_q;
		fph_d       = fph_q;
		want        = 1'b0;
		drive       = 1'b0;
		entered     = 1'b0;
		fs_go       = 1'b0;
		age         = '0;
		limit       = '0;

		if (item.kind == KIND_TICK) begin
			tsp_d = (tsp_q == TICK_MAX) ? TICK_MAX : tsp_q + 1'b1;
			tsi_d = (tsi_q == TICK_MAX) ? TICK_MAX : tsi_q + 1'b1;
			fph_d = (fph_q == TICK_MAX) ? TICK_MAX : fph_q + 1'b1;
			if (item.ignition != ign_q) begin
				ign_d = item.ignition;
				tsi_d = '0;
				// ignition off drops the relay; the failsafe clear below follows charge
				if (!item.ignition) begin
					relay_d    = 1'b0;
					charge_d   = 1'b0;
					have_pkt_d = 1'b0;
					mismatch_d = 1'b0;
				end
			end
			age = have_pkt_d ? tsp_d : tsi_d;
			fs_go = ign_d && (cfg.stale_ticks != '0) &&
				(CMP_W'(age) >= CMP_W'(cfg.stale_ticks));
			if (fs_go) begin
				if (!fs_active_d) begin
					entered     = 1'b1;
					fs_active_d = 1'b1;
					fph_d       = '0;
				end
				case (cfg.failsafe_mode)
					FS_MODE_ON: want = 1'b1;
					FS_MODE_CYCLE: begin
						if (cfg.failsafe_on_ticks == '0 || cfg.failsafe_off_ticks == '0) begin
							want = 1'b1;
						end else begin
							if (!fs_out_d && fph_d == '0) begin
								fs_out_d = 1'b1;
								drive    = 1'b1;
							end
							limit = fs_out_d ? cfg.failsafe_on_ticks : cfg.failsafe_off_ticks;
							if (CMP_W'(fph_d) >= CMP_W'(limit)) begin
								fs_out_d = !fs_out_d;
								fph_d    = '0;
								drive    = 1'b1;
							end
							want = fs_out_d;
						end
					end
					default: want = 1'b0;
				endcase
				if (want != fs_out_d) begin
					fs_out_d = want;
					fph_d    = '0;
					drive    = 1'b1;
				end
				if (drive || entered) relay_d = want;
			end else if (fs_active_d) begin
				fs_active_d = 1'b0;
				fph_d       = '0;
				fs_out_d    = 1'b0;
				relay_d     = charge_d;
			end
			if (!ign_d) led_d = LED_OFF;
			else if (have_pkt_d && CMP_W'(tsp_d) <= CMP_W'(cfg.led_seen_ticks)) led_d = LED_LINK;
			else led_d = LED_NO_LINK;
		end else if (ign_q) begin
			have_pkt_d = 1'b1;
			tsp_d      = '0;
			if (fs_active_q) begin
				fs_active_d = 1'b0;
				fph_d       = '0;
				fs_out_d    = 1'b0;
				relay_d     = charge_q;
			end
			if (item.batt_level <= cfg.max_valid_percent) begin
				if (init_pend_q) begin
					if (item.batt_level >= cfg.stop_percent) begin
						init_pend_d = 1'b0;
						charge_d    = 1'b0;
						relay_d     = 1'b0;
					end else if (!charge_q) begin
						charge_d = 1'b1;
						relay_d  = 1'b1;
					end
				end else if (!charge_q) begin
					if (item.batt_level <= cfg.start_percent) begin
						charge_d = 1'b1;
						relay_d  = 1'b1;
					end
				end else if (item.batt_level >= cfg.stop_percent) begin
					charge_d = 1'b0;
					relay_d  = 1'b0;
				end
			end
			mismatch_d = relay_d && !item.charge_flag;
			// ignition is on here and the packet age is zero
			led_d = (CMP_W'(tsp_d) <= CMP_W'(cfg.led_seen_ticks)) ? LED_LINK : LED_NO_LINK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_q       <= 1'b0;
			init_pend_q <= 1'b1;
			charge_q    <= 1'b0;
			relay_q     <= 1'b0;
			have_pkt_q  <= 1'b0;
			fs_active_q <= 1'b0;
			fs_out_q    <= 1'b0;
			mismatch_q  <= 1'b0;
			led_q       <= LED_OFF;
			tsp_q       <= '0;
			tsi_q       <= '0;
			fph_q       <= '0;
		end else if (advance) begin
			ign_q       <= ign_d;
			init_pend_q <= init_pend_d;
			charge_q    <= charge_d;
			relay_q     <= relay_d;
			have_pkt_q  <= have_pkt_d;
			fs_active_q <= fs_active_d;
			fs_out_q    <= fs_out_d;
			mismatch_q  <= mismatch_d;
			led_q       <= led_d;
			tsp_q       <= tsp_d;
			tsi_q       <= tsi_d;
			fph_q       <= fph_d;
		end
	end

	assign result.relay_on       = relay_d;
	assign result.charging_state = charge_d;
	assign result.led_status     = led_d;
	assign result.failsafe_on    = fs_active_d;
	assign result.flag_mismatch  = mismatch_d;
	assign result.scan_enable    = ign_d;

endmodule

// File: design/battery_charge_relay_controller.sv
// ----------------------------------------------------------------------------
// battery_charge_relay_controller: charge relay control top level
// Input register, state update and result register for tick and packet items.
// ----------------------------------------------------------------------------
// result: an accepted item is held in the input register until its result is registered
// throughput: one item per cycle while out_stall does not hold a full result
// register, set by the single-pass update between the input and result registers
// reset: arst_n clears the state, restores register defaults and empties
// both stages; in_stall is then low, so the block takes an item straight after reset
module battery_charge_relay_controller #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             write_enable,
	input  logic [bcr_pkg::REG_INDEX_W-1:0]  reg_index,
	input  logic [bcr_pkg::REG_DATA_W-1:0]   write_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic                             ignition,
	input  logic [bcr_pkg::PCT_W-1:0]        batt_level,
	input  logic                             charge_flag,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             relay_on,
	output logic                             charging_state,
	output logic [bcr_pkg::LED_W-1:0]        led_status,
	output logic                             failsafe_on,
	output logic                             flag_mismatch,
	output logic                             scan_enable
);
	import bcr_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    item_valid_s1;
	result_t result;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	assign advance  = item_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = item_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (advance || !item_valid_s1) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.kind        <= kind;
			item_s1.ignition    <= ignition;
			item_s1.batt_level  <= batt_level;
			item_s1.charge_flag <= charge_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	bcr_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.cfg          (cfg)
	);

	bcr_core #(
		.TICK_COUNT_BITS (TICK_COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	assign out_valid      = out_valid_q;
	assign relay_on       = res_q.relay_on;
	assign charging_state = res_q.charging_state;
	assign led_status     = res_q.led_status;
	assign failsafe_on    = res_q.failsafe_on;
	assign flag_mismatch  = res_q.flag_mismatch;
	assign scan_enable    = res_q.scan_enable;

endmodule
